### rtl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Shared types, constants and small functions for the status LED blocks.
// ----------------------------------------------------------------------------
package slpg_pkg;

	// Default length of one breathing triangle, in milliseconds.
	localparam int unsigned BREATH_PERIOD_DEF = 3000;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ALERT_INTERVAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP        = 3'd4;

	localparam logic [15:0] ALERT_INTERVAL_RST  = 16'd150;
	localparam logic [15:0] BREATH_INTERVAL_RST = 16'd30;
	localparam logic [7:0]  BREATH_MIN_RST      = 8'd10;
	localparam logic [7:0]  BREATH_MAX_RST      = 8'd255;
	localparam logic [7:0]  HUE_STEP_RST        = 8'd1;

	// Update blink rate
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	localparam logic [4:0]  HZ_PER_PCT  = 5'd19;
	localparam logic [10:0] RECIP_100   = 11'd1311;
	localparam int unsigned RECIP_SHIFT = 17;
	localparam logic [4:0]  HZ_MIN      = 5'd1;
	localparam logic [4:0]  HZ_MAX      = 5'd20;
	// Half periods elapsed = ms * hz * 2 / 1000 = ms * hz / 500.
	localparam logic [15:0] BLINK_DIVISOR = 16'd500;

	// Shared divider. A reciprocal is floor((2^32 - 1) / d), which keeps the
	// estimated quotient at most one below the true one.
	localparam int unsigned DIVD_W = 32;
	localparam int unsigned DIVS_W = 16;
	localparam logic [DIVD_W-1:0] BLINK_RECIP = DIVD_W'(64'hFFFF_FFFF / 64'(BLINK_DIVISOR));

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Colour wheel segment bounds
	localparam logic [7:0] WHEEL_SEG1 = 8'd85;
	localparam logic [7:0] WHEEL_SEG2 = 8'd170;

	typedef enum logic [2:0] {
		OPC_TICK         = 3'd0,
		OPC_UPD_START    = 3'd1,
		OPC_UPD_PROGRESS = 3'd2,
		OPC_UPD_END      = 3'd3,
		OPC_UPD_ERROR    = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] now_ms;
		logic        link_up;
		logic        button_held;
		logic        invert_colors;
		logic [6:0]  ota_percent;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	typedef struct packed {
		opcode_t     op;
		logic [31:0] now_ms;
		logic        link_up;
		logic        button_held;
		logic        invert_colors;
		logic [4:0]  blink_hz;
	} cmd_t;

	typedef struct packed {
		logic [15:0] alert_interval_ms;
		logic [15:0] breath_interval_ms;
		logic [7:0]  breath_min_level;
		logic [7:0]  breath_max_level;
		logic [7:0]  hue_step;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
		logic [DIVD_W-1:0] recip;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
		logic [DIVS_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_EXEC,
		BK_POS_DIV,
		BK_LEVEL_DIV,
		BK_MUL,
		BK_SCALE,
		BK_BLINK_DIV,
		BK_BLINK_FRAC,
		BK_EMIT
	} back_state_t;

	localparam result_t COLOR_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
	localparam result_t COLOR_RED   = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
	localparam result_t COLOR_GREEN = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
	localparam result_t COLOR_BLUE  = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	// Three-segment colour wheel, full brightness.
	function automatic result_t color_wheel(input logic [7:0] hue);
		logic [7:0] p;
		logic [7:0] seg;
		logic [8:0] tri3;
		logic [7:0] up;
		result_t    c;
		p = 8'd255 - hue;
		if (p < WHEEL_SEG1) begin
			seg = p;
		end else if (p < WHEEL_SEG2) begin
			seg = p - WHEEL_SEG1;
		end else begin
			seg = p - WHEEL_SEG2;
		end
		tri3 = {1'b0, seg} + {seg, 1'b0};
		up = tri3[7:0];
		if (p < WHEEL_SEG1) begin
			c = '{red: 8'd255 - up, green: 8'd0, blue: up};
		end else if (p < WHEEL_SEG2) begin
			c = '{red: 8'd0, green: up, blue: 8'd255 - up};
		end else begin
			c = '{red: up, green: 8'd255 - up, blue: 8'd0};
		end
		return c;
	endfunction

endpackage

### rtl/slpg_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Divides by a constant through a reciprocal multiply and one correction step;
// operand, estimate, remainder and result registers; one-cycle done pulse.
// ----------------------------------------------------------------------------
module slpg_div
	import slpg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIVD_W-1:0] dividend_q;
	logic [DIVS_W-1:0] divisor_q;
	logic [DIVD_W-1:0] recip_q;
	logic              busy_s1, busy_s2, busy_s3;
	logic [DIVD_W-1:0] qest_s2, qest_s3;
	logic [DIVD_W-1:0] diff_s3;
	logic [DIVD_W-1:0] quot_q;
	logic [DIVS_W-1:0] rem_q;
	logic              done_q;

	logic [2*DIVD_W-1:0]      recip_prod;
	logic [DIVD_W+DIVS_W-1:0] back_prod;
	logic [DIVD_W-1:0]        diff;
	logic                     fix;
	logic [DIVD_W-1:0]        diff_fixed;

	// The estimate is the true quotient or one below it, so the partial
	// remainder stays under twice the divisor and one subtract finishes it.
	always_comb begin
		recip_prod = {{DIVD_W{1'b0}}, dividend_q} * {{DIVD_W{1'b0}}, recip_q};
		back_prod  = {{DIVS_W{1'b0}}, qest_s2} * {{DIVD_W{1'b0}}, divisor_q};
		diff       = dividend_q - back_prod[DIVD_W-1:0];
		fix        = diff_s3 >= {{(DIVD_W-DIVS_W){1'b0}}, divisor_q};
		diff_fixed = fix ? diff_s3 - {{(DIVD_W-DIVS_W){1'b0}}, divisor_q} : diff_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			busy_s2 <= 1'b0;
			busy_s3 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy_s1 <= req.start;
			busy_s2 <= busy_s1;
			busy_s3 <= busy_s2;
			done_q  <= busy_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			recip_q    <= req.recip;
		end
		qest_s2 <= recip_prod[2*DIVD_W-1:DIVD_W];
		qest_s3 <= qest_s2;
		diff_s3 <= diff;
		if (busy_s3) begin
			quot_q <= qest_s3 + DIVD_W'(fix);
			rem_q  <= diff_fixed[DIVS_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule

### rtl/slpg_front.sv
// ----------------------------------------------------------------------------
// Status LED front end
// Accepts input words, drops unknown opcodes and turns progress into a rate.
// ----------------------------------------------------------------------------
module slpg_front
	import slpg_pkg::*;
(
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  q_full,
	output logic  push,
	output cmd_t  push_cmd
);

	logic        known;
	logic [6:0]  pct_sat;
	logic [10:0] pct_x19;
	logic [21:0] recip_prod;
	logic [4:0]  hz;

	// Rate is 1 + pct * 19 / 100; the divide by 100 is a reciprocal multiply.
	always_comb begin
		pct_sat    = (item.ota_percent > PCT_MAX) ? PCT_MAX : item.ota_percent;
		pct_x19    = {4'd0, pct_sat} * {6'd0, HZ_PER_PCT};
		recip_prod = {11'd0, pct_x19} * {11'd0, RECIP_100};
		hz         = recip_prod[RECIP_SHIFT+4:RECIP_SHIFT] + HZ_MIN;
	end

	always_comb begin
		case (item.opcode)
			OPC_TICK, OPC_UPD_START, OPC_UPD_PROGRESS, OPC_UPD_END, OPC_UPD_ERROR: begin
				known = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full && known;

	always_comb begin
		push_cmd.op            = opcode_t'(item.opcode);
		push_cmd.now_ms        = item.now_ms;
		push_cmd.link_up       = item.link_up;
		push_cmd.button_held   = item.button_held;
		push_cmd.invert_colors = item.invert_colors;
		push_cmd.blink_hz      = hz;
	end

endmodule

### rtl/slpg_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short register FIFO that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module slpg_queue
	import slpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic not_empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/slpg_back.sv
// ----------------------------------------------------------------------------
// Status LED back end
// Sequencer that runs one command at a time and holds the pattern state.
// ----------------------------------------------------------------------------
module slpg_back
	import slpg_pkg::*;
#(
	parameter int unsigned BREATH_PERIOD = BREATH_PERIOD_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  cmd_t    head,
	input  logic    q_valid,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam logic [DIVS_W-1:0] PERIOD = DIVS_W'(BREATH_PERIOD);
	localparam logic [DIVS_W-1:0] HALF   = DIVS_W'(BREATH_PERIOD / 2);
	localparam logic [DIVD_W-1:0] PERIOD_RECIP = DIVD_W'(64'hFFFF_FFFF / 64'(BREATH_PERIOD));
	localparam logic [DIVD_W-1:0] HALF_RECIP   =
		DIVD_W'(64'hFFFF_FFFF / 64'(BREATH_PERIOD / 2));

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	back_state_t state_q, state_d, exec_next;

	// Pattern state
	logic        prev_link_q;
	logic        alert_started_q;
	logic        alert_is_red_q;
	logic [31:0] last_alert_ms_q;
	logic [31:0] last_breath_ms_q;
	logic [7:0]  hue_q;
	logic        update_active_q;
	logic        update_led_on_q;
	logic [31:0] update_start_ms_q;
	logic [4:0]  update_blink_hz_q;

	// Working registers
	cmd_t        cmd_q;
	result_t     color_q;
	result_t     wheel_q;
	logic [7:0]  level_q;
	logic        rising_q;
	logic        blink_a0_q;
	logic [15:0] prod_q;
	logic [1:0]  ch_q;
	logic        result_valid_q;
	result_t     result_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;

	result_t     exec_color;
	logic        started_eff;
	logic [31:0] alert_elapsed, breath_elapsed, blink_elapsed;
	logic        alert_due, breath_due;
	logic [13:0] blink_frac;
	logic        blink_on;
	logic [7:0]  lvl_hi, lvl_lo, lvl_span, lvl_q8;
	logic [15:0] pos, pos_off;
	logic        pos_rising;
	logic [23:0] lvl_prod;
	logic [7:0]  wheel_ch, scaled, chan_out;
	logic        out_free, out_load;

	slpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Arithmetic shared by the states
	always_comb begin
		// A tick that follows a link loss restarts the alert with red.
		started_eff    = alert_started_q && !prev_link_q;
		alert_elapsed  = cmd_q.now_ms - last_alert_ms_q;
		breath_elapsed = cmd_q.now_ms - last_breath_ms_q;
		blink_elapsed  = cmd_q.now_ms - update_start_ms_q;
		alert_due      = alert_elapsed >= {16'd0, cfg.alert_interval_ms};
		breath_due     = breath_elapsed >= {16'd0, cfg.breath_interval_ms};
		// With ms = 500 * a + b, the half-period count is a * hz plus
		// b * hz / 500, so only its lowest bit needs a and hz.
		blink_frac     = {5'd0, div_rsp.remainder[8:0]} * {9'd0, update_blink_hz_q};
		blink_on       = !((blink_a0_q & update_blink_hz_q[0]) ^ div_rsp.quotient[0]);

		lvl_hi     = cfg.breath_max_level;
		lvl_lo     = (cfg.breath_min_level > lvl_hi) ? lvl_hi : cfg.breath_min_level;
		lvl_span   = lvl_hi - lvl_lo;
		pos        = div_rsp.remainder;
		pos_rising = pos < HALF;
		pos_off    = pos_rising ? pos : pos - HALF;
		lvl_prod   = {16'd0, lvl_span} * {8'd0, pos_off};
		lvl_q8     = div_rsp.quotient[7:0];

		scaled   = div255(prod_q);
		chan_out = cmd_q.invert_colors ? 8'd255 - scaled : scaled;
	end

	always_comb begin
		case (ch_q)
			CH_RED:   wheel_ch = wheel_q.red;
			CH_GREEN: wheel_ch = wheel_q.green;
			default:  wheel_ch = wheel_q.blue;
		endcase
	end

	// Where a command goes after its first cycle
	always_comb begin
		exec_next  = BK_IDLE;
		exec_color = COLOR_BLACK;
		case (cmd_q.op)
			OPC_TICK: begin
				if (!cmd_q.link_up) begin
					if (!started_eff) begin
						exec_next  = BK_EMIT;
						exec_color = COLOR_RED;
					end else if (alert_due) begin
						exec_next  = BK_EMIT;
						exec_color = alert_is_red_q ? COLOR_BLUE : COLOR_RED;
					end
				end else if (update_active_q) begin
					exec_next = BK_BLINK_DIV;
				end else if (cmd_q.button_held) begin
					exec_next  = BK_EMIT;
					exec_color = COLOR_GREEN;
				end else if (breath_due) begin
					exec_next = BK_POS_DIV;
				end
			end
			OPC_UPD_START: begin
				exec_next  = BK_EMIT;
				exec_color = COLOR_BLUE;
			end
			OPC_UPD_END: begin
				exec_next  = BK_EMIT;
				exec_color = COLOR_GREEN;
			end
			default: begin
				exec_next = BK_IDLE;
			end
		endcase
	end

	assign out_free = !result_valid_q || !result_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) state_d = BK_EXEC;
			end
			BK_EXEC: begin
				state_d = exec_next;
			end
			BK_POS_DIV: begin
				if (div_rsp.done) state_d = BK_LEVEL_DIV;
			end
			BK_LEVEL_DIV: begin
				if (div_rsp.done) state_d = BK_MUL;
			end
			BK_MUL: begin
				state_d = BK_SCALE;
			end
			BK_SCALE: begin
				state_d = (ch_q == CH_BLUE) ? BK_EMIT : BK_MUL;
			end
			BK_BLINK_DIV: begin
				if (div_rsp.done) state_d = BK_BLINK_FRAC;
			end
			BK_BLINK_FRAC: begin
				if (div_rsp.done) begin
					state_d = (blink_on != update_led_on_q) ? BK_EMIT : BK_IDLE;
				end
			end
			BK_EMIT: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		pop              = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIVD_W'(cmd_q.now_ms);
		div_req.divisor  = PERIOD;
		div_req.recip    = PERIOD_RECIP;
		case (state_q)
			BK_IDLE: begin
				pop = q_valid;
			end
			BK_EXEC: begin
				if (exec_next == BK_POS_DIV) begin
					div_req.start = 1'b1;
				end else if (exec_next == BK_BLINK_DIV) begin
					div_req.start    = 1'b1;
					div_req.dividend = blink_elapsed;
					div_req.divisor  = BLINK_DIVISOR;
					div_req.recip    = BLINK_RECIP;
				end
			end
			BK_POS_DIV: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = DIVD_W'(lvl_prod);
				div_req.divisor  = HALF;
				div_req.recip    = HALF_RECIP;
			end
			BK_BLINK_DIV: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = DIVD_W'(blink_frac);
				div_req.divisor  = BLINK_DIVISOR;
				div_req.recip    = BLINK_RECIP;
			end
			BK_EMIT: begin
				out_load = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= BK_IDLE;
			prev_link_q       <= 1'b0;
			alert_started_q   <= 1'b0;
			alert_is_red_q    <= 1'b0;
			last_alert_ms_q   <= '0;
			last_breath_ms_q  <= '0;
			hue_q             <= '0;
			update_active_q   <= 1'b0;
			update_led_on_q   <= 1'b0;
			update_start_ms_q <= '0;
			update_blink_hz_q <= HZ_MIN;
			result_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (state_q == BK_EXEC) begin
				case (cmd_q.op)
					OPC_TICK: begin
						prev_link_q <= cmd_q.link_up;
						if (!cmd_q.link_up) begin
							alert_started_q <= 1'b1;
							if (!started_eff) begin
								last_alert_ms_q <= cmd_q.now_ms;
								alert_is_red_q  <= 1'b1;
							end else if (alert_due) begin
								last_alert_ms_q <= cmd_q.now_ms;
								alert_is_red_q  <= !alert_is_red_q;
							end
						end else if (exec_next == BK_POS_DIV) begin
							last_breath_ms_q <= cmd_q.now_ms;
							hue_q            <= hue_q + cfg.hue_step;
						end
					end
					OPC_UPD_START: begin
						update_active_q   <= 1'b1;
						update_blink_hz_q <= HZ_MIN;
						update_led_on_q   <= 1'b1;
						update_start_ms_q <= cmd_q.now_ms;
					end
					OPC_UPD_PROGRESS: begin
						update_blink_hz_q <= cmd_q.blink_hz;
					end
					OPC_UPD_END, OPC_UPD_ERROR: begin
						update_active_q <= 1'b0;
					end
					default: begin
						update_active_q <= update_active_q;
					end
				endcase
			end
			if (state_q == BK_BLINK_FRAC && div_rsp.done) begin
				update_led_on_q <= blink_on;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (out_load) begin
			result_q <= color_q;
		end
		case (state_q)
			BK_EXEC: begin
				color_q <= exec_color;
			end
			BK_POS_DIV: begin
				rising_q <= pos_rising;
			end
			BK_LEVEL_DIV: begin
				level_q <= rising_q ? lvl_lo + lvl_q8 : lvl_hi - lvl_q8;
				wheel_q <= color_wheel(hue_q);
				ch_q    <= CH_RED;
			end
			BK_MUL: begin
				prod_q <= {8'd0, wheel_ch} * {8'd0, level_q};
			end
			BK_SCALE: begin
				case (ch_q)
					CH_RED:   color_q.red   <= chan_out;
					CH_GREEN: color_q.green <= chan_out;
					default:  color_q.blue  <= chan_out;
				endcase
				ch_q <= ch_q + 2'd1;
			end
			BK_BLINK_DIV: begin
				blink_a0_q <= div_rsp.quotient[0];
			end
			BK_BLINK_FRAC: begin
				color_q <= blink_on ? COLOR_BLUE : COLOR_BLACK;
			end
			default: begin
				ch_q <= ch_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_div_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == BK_POS_DIV || state_q == BK_LEVEL_DIV ||
			state_q == BK_BLINK_DIV || state_q == BK_BLINK_FRAC))
		else $error("divider finished while the sequencer was not waiting for it");

	a_exec_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC) |-> $past(pop))
		else $error("command executed without being taken from the queue");

	a_blink_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(update_blink_hz_q >= HZ_MIN) && (update_blink_hz_q <= HZ_MAX))
		else $error("update blink rate out of range");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT && !result_valid_q) |=> result_valid_q)
		else $error("colour ready for an empty output register was not loaded");

	a_channel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL || state_q == BK_SCALE) |-> (ch_q <= CH_BLUE))
		else $error("channel counter ran past blue");
`endif

endmodule

### rtl/status_led_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator
// Turns timed events into colours for one RGB status LED.
// ----------------------------------------------------------------------------
// Each input word is an event; a result word is a colour to apply, and an
// event gives at most one. The front end accepts a word in any cycle while its
// two-entry command queue has room, and the result register lets the next
// command run while a colour still waits to be taken. Commands run one at a
// time in the back end; an update blink tick gives a colour only when the LED
// level changes. Blink and breathing ticks use the shared divider, which
// multiplies by a reciprocal of its constant divisor and corrects the
// estimate with one compare and subtract, two divisions per blink or
// breathing tick. A colour that finds the result register still held waits
// in the back end until the register is taken. The configuration port is
// always ready and should be written only while the block has no command in
// flight.
module status_led_pattern_generator_top
	import slpg_pkg::*;
#(
	parameter int unsigned BREATH_PERIOD = BREATH_PERIOD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full, q_push, q_pop, q_valid;
	cmd_t push_cmd, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alert_interval_ms  <= ALERT_INTERVAL_RST;
			cfg_q.breath_interval_ms <= BREATH_INTERVAL_RST;
			cfg_q.breath_min_level   <= BREATH_MIN_RST;
			cfg_q.breath_max_level   <= BREATH_MAX_RST;
			cfg_q.hue_step           <= HUE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ALERT_INTERVAL:  cfg_q.alert_interval_ms  <= cfg_data;
				CFG_BREATH_INTERVAL: cfg_q.breath_interval_ms <= cfg_data;
				CFG_BREATH_MIN:      cfg_q.breath_min_level   <= cfg_data[7:0];
				CFG_BREATH_MAX:      cfg_q.breath_max_level   <= cfg_data[7:0];
				CFG_HUE_STEP:        cfg_q.hue_step           <= cfg_data[7:0];
				default:             cfg_q                    <= cfg_q;
			endcase
		end
	end

	slpg_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (q_push),
		.push_cmd   (push_cmd)
	);

	slpg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head),
		.not_empty (q_valid)
	);

	slpg_back #(
		.BREATH_PERIOD (BREATH_PERIOD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_valid      (q_valid),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### tb/sv/status_led_pattern_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status LED pattern generator testbench
// Sends timed LED events over the valid/stall input port and predicts the
// color word, if any, that each one should give. Every word taken from the result port
// is checked field by field against the oldest prediction. The register set
// is reprogrammed between phases, including the extreme settings. Random idle
// cycles are applied on both ports, and the receiver holds off for one long
// stretch.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_top_tb;
	import slpg_pkg::*;

	localparam int unsigned BREATH_MS    = 3000;
	localparam int unsigned MAX_IDLE     = 18;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned QUIET        = 300;
	localparam int unsigned DRAIN_LIMIT  = 100000;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_EVENTS = 310;

	localparam result_t LED_OFF   = 24'h000000;
	localparam result_t LED_RED   = 24'hFF0000;
	localparam result_t LED_GREEN = 24'h00FF00;
	localparam result_t LED_BLUE  = 24'h0000FF;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	status_led_pattern_generator_top #(
		.BREATH_PERIOD(BREATH_MS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Register copies used by the predictor.
	logic [15:0] alert_gap  = 16'd150;
	logic [15:0] breath_gap = 16'd30;
	logic [7:0]  lvl_lo     = 8'd10;
	logic [7:0]  lvl_hi     = 8'd255;
	logic [7:0]  hue_inc    = 8'd1;

	// Predicted LED state.
	logic        link_was_up = 1'b0;
	logic        alert_on    = 1'b0;
	logic        alert_red   = 1'b0;
	logic [31:0] alert_mark  = '0;
	logic [31:0] breath_mark = '0;
	logic [7:0]  wheel_hue   = '0;
	logic        upd_on      = 1'b0;
	logic        upd_lit     = 1'b0;
	logic [31:0] upd_t0      = '0;
	logic [4:0]  upd_hz      = 5'd1;

	item_t       event_queue[$];
	result_t     pending_colors[$];
	int unsigned pushed_cnt     = 0;
	int unsigned accepted_cnt   = 0;
	int unsigned events_queued  = 0;
	int unsigned colors_checked = 0;
	int unsigned settings_cnt   = 0;
	int unsigned fail_cnt       = 0;
	int unsigned send_wait      = 0;
	int unsigned recv_wait      = 0;
	int unsigned send_calm      = 0;
	int unsigned recv_calm      = 0;
	logic        hold_req       = 1'b0;
	logic        hold_taken     = 1'b0;
	logic [31:0] t_ms           = '0;
	int unsigned step_cap       = 40;

	function automatic logic alert_step(input logic [31:0] now, output result_t c);
		c = LED_OFF;
		if (!alert_on) begin
			alert_on = 1'b1;
			alert_mark = now;
			alert_red = 1'b1;
			c = LED_RED;
			return 1'b1;
		end
		if (now - alert_mark >= {16'd0, alert_gap}) begin
			alert_mark = now;
			alert_red = ~alert_red;
			c = alert_red ? LED_RED : LED_BLUE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic blink_step(input logic [31:0] now, output result_t c);
		logic [31:0] since;
		logic [63:0] halves;
		logic        lit;
		since = now - upd_t0;
		// The product is taken at full width, so long updates do not wrap.
		halves = ({32'd0, since} * {59'd0, upd_hz} * 64'd2) / 64'd1000;
		lit = ~halves[0];
		c = lit ? LED_BLUE : LED_OFF;
		if (lit == upd_lit) begin
			return 1'b0;
		end
		upd_lit = lit;
		return 1'b1;
	endfunction

	function automatic logic breath_step(input logic [31:0] now, input logic inv,
			output result_t c);
		int unsigned pos, lo, hi, span, level, p, r, g, b;
		c = LED_OFF;
		if (now - breath_mark < {16'd0, breath_gap}) begin
			return 1'b0;
		end
		breath_mark = now;
		wheel_hue = wheel_hue + hue_inc;
		pos = now % BREATH_MS;
		hi = lvl_hi;
		lo = (lvl_lo > lvl_hi) ? lvl_hi : lvl_lo;
		span = hi - lo;
		if (pos < BREATH_MS / 2) begin
			level = lo + (span * pos) / (BREATH_MS / 2);
		end else begin
			level = hi - (span * (pos - BREATH_MS / 2)) / (BREATH_MS / 2);
		end
		p = 255 - wheel_hue;
		if (p < 85) begin
			r = 255 - 3 * p;
			g = 0;
			b = 3 * p;
		end else if (p < 170) begin
			p = p - 85;
			r = 0;
			g = 3 * p;
			b = 255 - 3 * p;
		end else begin
			p = p - 170;
			r = 3 * p;
			g = 255 - 3 * p;
			b = 0;
		end
		r = (r * level) / 255;
		g = (g * level) / 255;
		b = (b * level) / 255;
		if (inv) begin
			r = 255 - r;
			g = 255 - g;
			b = 255 - b;
		end
		c.red = 8'(r);
		c.green = 8'(g);
		c.blue = 8'(b);
		return 1'b1;
	endfunction

	// Returns 1 when the event gives a color word, which is then in c.
	function automatic logic next_led_color(input item_t w, output result_t c);
		int unsigned pct;
		c = LED_OFF;
		case (w.opcode)
			OPC_TICK: begin
				if (!w.link_up && link_was_up) begin
					alert_on = 1'b0;
				end
				link_was_up = w.link_up;
				if (!w.link_up) begin
					return alert_step(w.now_ms, c);
				end
				if (upd_on) begin
					return blink_step(w.now_ms, c);
				end
				if (w.button_held) begin
					c = LED_GREEN;
					return 1'b1;
				end
				return breath_step(w.now_ms, w.invert_colors, c);
			end
			OPC_UPD_START: begin
				upd_on = 1'b1;
				upd_hz = 5'd1;
				upd_lit = 1'b1;
				upd_t0 = w.now_ms;
				c = LED_BLUE;
				return 1'b1;
			end
			OPC_UPD_PROGRESS: begin
				pct = (w.ota_percent > 7'd100) ? 100 : w.ota_percent;
				upd_hz = 5'(1 + (pct * 19) / 100);
				return 1'b0;
			end
			OPC_UPD_END: begin
				upd_on = 1'b0;
				c = LED_GREEN;
				return 1'b1;
			end
			OPC_UPD_ERROR: begin
				upd_on = 1'b0;
				return 1'b0;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Idle cycles for one word, with occasional runs of back-to-back words.
	function automatic int unsigned idle_draw(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, MAX_IDLE);
	endfunction

	always @(posedge clk or negedge arst_n) begin : event_driver
		result_t c;
		logic    take;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_wait <= 0;
		end else begin
			take = item_valid && !item_stall;
			if (take) begin
				if (next_led_color(item, c)) begin
					pending_colors.push_back(c);
				end
				accepted_cnt++;
			end
			// A stalled word stays on the bus unchanged.
			if (!item_valid || take) begin
				if (send_wait != 0) begin
					item_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (event_queue.size() != 0) begin
					item <= event_queue.pop_front();
					item_valid <= 1'b1;
					send_wait <= idle_draw(send_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : color_checker
		int unsigned wait_n;
		result_t     want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			wait_n = recv_wait;
			if (result_valid && !result_stall) begin
				colors_checked++;
				if (pending_colors.size() == 0) begin
					$error("color word with none expected: red %0d green %0d blue %0d",
						result.red, result.green, result.blue);
					fail_cnt++;
				end else begin
					want = pending_colors.pop_front();
					if (result.red !== want.red) begin
						$error("red: expected %0d, actual %0d", want.red, result.red);
						fail_cnt++;
					end
					if (result.green !== want.green) begin
						$error("green: expected %0d, actual %0d", want.green, result.green);
						fail_cnt++;
					end
					if (result.blue !== want.blue) begin
						$error("blue: expected %0d, actual %0d", want.blue, result.blue);
						fail_cnt++;
					end
				end
				wait_n = idle_draw(recv_calm);
			end
			if (hold_req && !hold_taken) begin
				wait_n = LONG_HOLD;
				hold_taken <= 1'b1;
			end
			if (wait_n != 0) begin
				result_stall <= 1'b1;
				recv_wait <= wait_n - 1;
			end else begin
				result_stall <= 1'b0;
				recv_wait <= 0;
			end
		end
	end

	task automatic queue_event(input logic [2:0] op, input logic [31:0] now, input logic lk,
			input logic bt, input logic iv, input logic [6:0] pct);
		item_t w;
		w.opcode = op;
		w.now_ms = now;
		w.link_up = lk;
		w.button_held = bt;
		w.invert_colors = iv;
		w.ota_percent = pct;
		event_queue.push_back(w);
		pushed_cnt++;
		if (op <= OPC_UPD_ERROR) begin
			events_queued++;
		end
	endtask

	function automatic logic [31:0] advance();
		case ($urandom_range(0, 39))
			0: t_ms = $urandom;
			1: t_ms = t_ms + $urandom_range(0, 70000);
			default: t_ms = t_ms + $urandom_range(0, step_cap);
		endcase
		return t_ms;
	endfunction

	// Called just after the clock rises; the caller lowers cfg_valid afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			CFG_ALERT_INTERVAL: alert_gap = val;
			CFG_BREATH_INTERVAL: breath_gap = val;
			CFG_BREATH_MIN: lvl_lo = val[7:0];
			CFG_BREATH_MAX: lvl_hi = val[7:0];
			CFG_HUE_STEP: hue_inc = val[7:0];
			default: ;
		endcase
	endtask

	task automatic program_leds(input logic [15:0] alert_ms, input logic [15:0] breath_ms,
			input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] step);
		write_reg(CFG_ALERT_INTERVAL, alert_ms);
		write_reg(CFG_BREATH_INTERVAL, breath_ms);
		write_reg(CFG_BREATH_MIN, lo);
		write_reg(CFG_BREATH_MAX, hi);
		write_reg(CFG_HUE_STEP, step);
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	task automatic wait_drained();
		int unsigned n;
		n = 0;
		while ((accepted_cnt != pushed_cnt || pending_colors.size() != 0) && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (accepted_cnt != pushed_cnt || pending_colors.size() != 0) begin
			$error("%0d color words never arrived", pending_colors.size());
			fail_cnt++;
		end
	endtask

	// Events that give no color may still be in flight after the last word.
	task automatic settle();
		wait_drained();
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic fill_phase(input int unsigned n_events);
		int unsigned target, k, j;
		logic        iv;
		logic [6:0]  pct;
		target = events_queued + n_events;
		while (events_queued < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					iv = 1'($urandom);
					k = $urandom_range(3, 15);
					for (j = 0; j < k; j++) begin
						queue_event(OPC_TICK, advance(), 1'b1, $urandom_range(0, 15) == 0, iv,
							7'($urandom));
					end
				end
				4: begin
					k = $urandom_range(2, 12);
					for (j = 0; j < k; j++) begin
						queue_event(OPC_TICK, advance(), 1'b0, 1'($urandom), 1'($urandom),
							7'($urandom));
					end
				end
				5: begin
					k = $urandom_range(1, 5);
					for (j = 0; j < k; j++) begin
						queue_event(OPC_TICK, advance(), 1'b1, 1'b1, 1'($urandom), 7'($urandom));
					end
				end
				6, 7, 8: begin
					queue_event(OPC_UPD_START, advance(), 1'b1, 1'b0, 1'b0, 7'($urandom));
					k = $urandom_range(2, 20);
					for (j = 0; j < k; j++) begin
						case ($urandom_range(0, 5))
							0: begin
								pct = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
									: 7'($urandom_range(0, 100));
								queue_event(OPC_UPD_PROGRESS, advance(), 1'($urandom),
									1'($urandom), 1'($urandom), pct);
							end
							1: queue_event(OPC_TICK, advance(), $urandom_range(0, 3) != 0,
								1'($urandom), 1'($urandom), 7'($urandom));
							default: queue_event(OPC_TICK, advance(), 1'b1, 1'($urandom),
								1'($urandom), 7'($urandom));
						endcase
					end
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: queue_event(OPC_UPD_END, advance(), 1'($urandom),
							1'($urandom), 1'($urandom), 7'($urandom));
						6, 7, 8: queue_event(OPC_UPD_ERROR, advance(), 1'($urandom),
							1'($urandom), 1'($urandom), 7'($urandom));
						default: ;
					endcase
				end
				default: begin
					k = $urandom_range(1, 3);
					for (j = 0; j < k; j++) begin
						queue_event(3'($urandom), $urandom, 1'($urandom), 1'($urandom),
							1'($urandom), 7'($urandom));
					end
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int unsigned ph;
		logic [7:0]  lo, hi, tmp;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events under the reset settings.
		queue_event(OPC_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd149, 1'b0, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd150, 1'b0, 1'b1, 1'b1, 7'd0);
		queue_event(OPC_TICK, 32'd200, 1'b1, 1'b1, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd210, 1'b0, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd1000, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd1500, 1'b1, 1'b0, 1'b1, 7'd0);
		queue_event(OPC_TICK, 32'd1510, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd2999, 1'b1, 1'b0, 1'b0, 7'h7F);
		queue_event(OPC_UPD_START, 32'd3000, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_UPD_PROGRESS, 32'd3000, 1'b0, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd3400, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd3500, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_UPD_PROGRESS, 32'd3500, 1'b1, 1'b1, 1'b1, 7'd100);
		// Percent above a hundred saturates at the top rate.
		queue_event(OPC_UPD_PROGRESS, 32'd3500, 1'b0, 1'b0, 1'b0, 7'd127);
		queue_event(OPC_TICK, 32'd3525, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'd3550, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 7'h7F);
		queue_event(OPC_UPD_ERROR, 32'd3600, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 7'd0);
		queue_event(3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 7'h7F);
		queue_event(3'd6, 32'd0, 1'b0, 1'b0, 1'b0, 7'd0);
		queue_event(3'd7, 32'h5555_AAAA, 1'b1, 1'b0, 1'b1, 7'd42);
		queue_event(OPC_UPD_END, 32'd5, 1'b1, 1'b0, 1'b0, 7'd0);
		queue_event(OPC_TICK, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 7'd0);
		// The time wraps here; the elapsed time must still count as 32 ms.
		queue_event(OPC_TICK, 32'h0000_0010, 1'b1, 1'b0, 1'b1, 7'd0);
		settle();

		t_ms = 32'd20;
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					program_leds(16'd1, 16'd1, 16'd0, 16'd255, 16'd255);
					step_cap = 8;
				end
				1: begin
					// Zero intervals and a minimum above the maximum.
					program_leds(16'd0, 16'd0, 16'd255, 16'd0, 16'd0);
					step_cap = 5;
				end
				2: begin
					program_leds(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd128);
					step_cap = 70000;
				end
				default: begin
					lo = 8'($urandom);
					hi = 8'($urandom);
					if ($urandom_range(0, 3) != 0 && lo > hi) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
					program_leds(16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)),
						{8'($urandom), lo}, {8'($urandom), hi}, 16'($urandom));
					step_cap = $urandom_range(5, 80);
				end
			endcase
			if (ph == 3) begin
				// The receiver stops for a long time while events keep coming.
				hold_req <= 1'b1;
			end
			if (ph == 4) begin
				fill_phase(PHASE_EVENTS / 2);
				wait_drained();
				fill_phase(PHASE_EVENTS - PHASE_EVENTS / 2);
			end else begin
				fill_phase(PHASE_EVENTS);
			end
			settle();
		end

		$display("Sent %0d LED events and checked %0d color words over %0d register settings.",
			events_queued, colors_checked, settings_cnt + 1);
		if (fail_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### files.f
rtl/slpg_pkg.sv
rtl/slpg_div.sv
rtl/slpg_front.sv
rtl/slpg_queue.sv
rtl/slpg_back.sv
rtl/status_led_pattern_generator_top.sv
tb/sv/status_led_pattern_generator_top_tb.sv
